/* rtl/core/trie_distinct_word_counter_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the trie distinct word counter
// Shared property wrappers, clocked on clk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef TRIE_DISTINCT_WORD_COUNTER_CORE_MACROS_SVH
`define TRIE_DISTINCT_WORD_COUNTER_CORE_MACROS_SVH

// Same-cycle implication.
`define TDWC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TDWC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/tdwc_pkg.sv */
// ----------------------------------------------------------------------------
// tdwc_pkg
// Sizes, codes and row helpers for the trie distinct word counter.
// ----------------------------------------------------------------------------
package tdwc_pkg;

    localparam int NODE_COUNT    = 4096;
    localparam int ALPHABET_SIZE = 26;

    localparam int NODE_W   = $clog2(NODE_COUNT);
    localparam int LETTER_W = 5;
    localparam int TAG_W    = 16;
    localparam int COUNT_W  = 16;
    localparam int ROW_W    = ALPHABET_SIZE * NODE_W;

    localparam logic [LETTER_W-1:0] LETTER_LIMIT = LETTER_W'(ALPHABET_SIZE);
    localparam logic [NODE_W-1:0]   NODE_LAST    = NODE_W'(NODE_COUNT - 1);
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef logic [ROW_W-1:0] link_row_t;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [COUNT_W-1:0] count;
    } node_word_t;

    // Pick the child link of one letter out of a node's link row.
    function automatic logic [NODE_W-1:0] get_link(input link_row_t row,
                                                   input logic [LETTER_W-1:0] ltr);
        logic [NODE_W-1:0] res;
        res = '0;
        for (int i = 0; i < ALPHABET_SIZE; i++) begin
            if (ltr == LETTER_W'(i)) begin
                res = row[i*NODE_W +: NODE_W];
            end
        end
        return res;
    endfunction

    // Replace the child link of one letter in a node's link row.
    function automatic link_row_t set_link(input link_row_t row,
                                           input logic [LETTER_W-1:0] ltr,
                                           input logic [NODE_W-1:0] child);
        link_row_t res;
        res = row;
        for (int i = 0; i < ALPHABET_SIZE; i++) begin
            if (ltr == LETTER_W'(i)) begin
                res[i*NODE_W +: NODE_W] = child;
            end
        end
        return res;
    endfunction

endpackage

/* rtl/core/tdwc_node_upd.sv */
// ----------------------------------------------------------------------------
// tdwc_node_upd
// Tag compare and saturating count update for one trie node.
// ----------------------------------------------------------------------------
module tdwc_node_upd
(
    input  logic [tdwc_pkg::TAG_W-1:0] word_tag,
    input  tdwc_pkg::node_word_t       stored,
    output tdwc_pkg::node_word_t       updated
);

    logic new_word;
    logic at_max;

    // Count a word only once per node: bump when the tag changes.
    assign new_word = (stored.tag != word_tag);
    assign at_max   = (stored.count == tdwc_pkg::COUNT_MAX);

    always_comb
    begin
        updated.tag   = word_tag;
        updated.count = stored.count;
        if (new_word && !at_max)
        begin
            updated.count = stored.count + 1'b1;
        end
    end

endmodule

/* rtl/core/trie_distinct_word_counter_core.sv */
// ----------------------------------------------------------------------------
// trie_distinct_word_counter_core
// Letter-at-a-time trie that counts distinct tagged words per prefix node.
// ----------------------------------------------------------------------------
// Each accepted word is one letter with a command (insert or query), a
// restart flag that moves the cursor back to the root, and the word tag.
// Every word gives exactly one result: the count of the node reached, a
// present flag, and pool_full when an insert needed a node and none was
// left. After reset the block sweeps both memories clear, one node row per
// cycle; in_ready stays low during that sweep. Afterwards a letter that
// reaches a node steps through accept, link row read, node read and result
// load, the two dependent reads of the link memory and the node memory
// being run by one small sequencer. A letter whose child is missing and
// cannot be allocated skips the node read, and a letter on an already
// missing path or out of range goes from accept straight to the result
// load. The result load waits while the output register still holds an
// untaken result. The next word is accepted as soon as the sequencer is
// back in idle, even while the previous result still waits on out_ready.
// ----------------------------------------------------------------------------
`include "trie_distinct_word_counter_core_macros.svh"

module trie_distinct_word_counter_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            command,
    input  logic [tdwc_pkg::LETTER_W-1:0]   letter,
    input  logic                            restart,
    input  logic [tdwc_pkg::TAG_W-1:0]      word_tag,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [tdwc_pkg::COUNT_W-1:0]    count,
    output logic                            present,
    output logic                            pool_full
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LINK,
        ST_NODE,
        ST_DONE
    } state_t;

    // Sequencer and trie walk state
    state_t                         state_reg;
    logic [tdwc_pkg::NODE_W-1:0]    clr_reg;
    logic [tdwc_pkg::NODE_W-1:0]    cursor_reg;
    logic [tdwc_pkg::NODE_W-1:0]    last_alloc_reg;
    logic                           missing_reg;

    // Captured word
    logic                           cmd_reg;
    logic [tdwc_pkg::LETTER_W-1:0]  letter_reg;
    logic [tdwc_pkg::TAG_W-1:0]     tag_reg;

    // Finished result waiting for the output register
    logic [tdwc_pkg::COUNT_W-1:0]   res_count_reg;
    logic                           res_present_reg;
    logic                           res_full_reg;

    // Output register
    logic                           out_valid_reg;
    logic [tdwc_pkg::COUNT_W-1:0]   count_reg;
    logic                           present_reg;
    logic                           pool_full_reg;

    // Memories: one link row per node, one tag/count word per node
    tdwc_pkg::link_row_t            link_mem [tdwc_pkg::NODE_COUNT];
    tdwc_pkg::node_word_t           node_mem [tdwc_pkg::NODE_COUNT];
    tdwc_pkg::link_row_t            link_q;
    tdwc_pkg::node_word_t           node_q;

    logic                           accept;
    logic                           out_load;
    logic [tdwc_pkg::NODE_W-1:0]    rd_cursor;
    logic                           eff_missing;
    logic                           letter_bad;
    logic [tdwc_pkg::NODE_W-1:0]    link_child;
    logic                           child_none;
    logic                           pool_used_up;
    logic [tdwc_pkg::NODE_W-1:0]    alloc_node;
    logic                           is_insert;
    logic                           node_go;
    logic [tdwc_pkg::NODE_W-1:0]    next_node;

    logic                           link_we;
    logic [tdwc_pkg::NODE_W-1:0]    link_wr_addr;
    tdwc_pkg::link_row_t            link_wr_data;
    logic                           node_rd_en;
    logic                           node_we;
    logic [tdwc_pkg::NODE_W-1:0]    node_wr_addr;
    tdwc_pkg::node_word_t           node_wr_data;
    tdwc_pkg::node_word_t           node_upd;

    // ------------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------------
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    assign out_valid = out_valid_reg;
    assign count     = count_reg;
    assign present   = present_reg;
    assign pool_full = pool_full_reg;

    // ------------------------------------------------------------------------
    // Walk decisions
    // ------------------------------------------------------------------------
    // Restart takes effect before the letter: root cursor, missing flag cleared.
    assign rd_cursor    = restart ? '0 : cursor_reg;
    assign eff_missing  = restart ? 1'b0 : missing_reg;
    assign letter_bad   = (letter >= tdwc_pkg::LETTER_LIMIT);

    assign is_insert    = (cmd_reg == tdwc_pkg::CMD_INSERT);
    assign link_child   = tdwc_pkg::get_link(link_q, letter_reg);
    assign child_none   = (link_child == '0);
    assign pool_used_up = (last_alloc_reg == tdwc_pkg::NODE_LAST);
    assign alloc_node   = last_alloc_reg + 1'b1;

    // Move on to a node when the child exists or an insert can allocate one.
    assign node_go   = !child_none || (is_insert && !pool_used_up);
    assign next_node = child_none ? alloc_node : link_child;

    // ------------------------------------------------------------------------
    // Link memory: read the cursor row at accept, write on clear or allocate
    // ------------------------------------------------------------------------
    always_comb
    begin
        link_we      = 1'b0;
        link_wr_addr = cursor_reg;
        link_wr_data = tdwc_pkg::set_link(link_q, letter_reg, alloc_node);
        if (state_reg == ST_CLEAR)
        begin
            link_we      = 1'b1;
            link_wr_addr = clr_reg;
            link_wr_data = '0;
        end
        else if ((state_reg == ST_LINK) && child_none && is_insert && !pool_used_up)
        begin
            link_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            link_q <= link_mem[rd_cursor];
        end
        if (link_we)
        begin
            link_mem[link_wr_addr] <= link_wr_data;
        end
    end

    // ------------------------------------------------------------------------
    // Node memory: read the reached node, write back the updated tag/count
    // ------------------------------------------------------------------------
    assign node_rd_en = (state_reg == ST_LINK) && node_go;

    tdwc_node_upd u_node_upd
    (
        .word_tag (tag_reg),
        .stored   (node_q),
        .updated  (node_upd)
    );

    always_comb
    begin
        node_we      = 1'b0;
        node_wr_addr = cursor_reg;
        node_wr_data = node_upd;
        if (state_reg == ST_CLEAR)
        begin
            node_we      = 1'b1;
            node_wr_addr = clr_reg;
            node_wr_data = '0;
        end
        else if ((state_reg == ST_NODE) && is_insert)
        begin
            node_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (node_rd_en)
        begin
            node_q <= node_mem[next_node];
        end
        if (node_we)
        begin
            node_mem[node_wr_addr] <= node_wr_data;
        end
    end

    // ------------------------------------------------------------------------
    // Captured word and pending result (payload, no reset)
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= command;
            letter_reg <= letter;
            tag_reg    <= word_tag;
        end
        if (out_load)
        begin
            count_reg     <= res_count_reg;
            present_reg   <= res_present_reg;
            pool_full_reg <= res_full_reg;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                // Dead paths and bad letters answer all zeros right away.
                res_count_reg   <= '0;
                res_present_reg <= 1'b0;
                res_full_reg    <= 1'b0;
            end
            ST_LINK:
            begin
                res_count_reg   <= '0;
                res_present_reg <= 1'b0;
                res_full_reg    <= child_none && is_insert && pool_used_up;
            end
            ST_NODE:
            begin
                res_count_reg   <= is_insert ? node_upd.count : node_q.count;
                res_present_reg <= 1'b1;
                res_full_reg    <= 1'b0;
            end
            default:
            begin
                res_count_reg   <= res_count_reg;
                res_present_reg <= res_present_reg;
                res_full_reg    <= res_full_reg;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            cursor_reg     <= '0;
            last_alloc_reg <= '0;
            missing_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // Load a finished result, or drop the output once taken.
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    // Sweep one node row per cycle.
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == tdwc_pkg::NODE_LAST)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_IDLE:
                begin
                    if (accept)
                    begin
                        cursor_reg <= rd_cursor;
                        if (eff_missing || letter_bad)
                        begin
                            missing_reg <= 1'b1;
                            state_reg   <= ST_DONE;
                        end
                        else
                        begin
                            missing_reg <= 1'b0;
                            state_reg   <= ST_LINK;
                        end
                    end
                end

                ST_LINK:
                begin
                    if (node_go)
                    begin
                        // Advance the cursor; allocate the child if missing.
                        cursor_reg <= next_node;
                        if (child_none)
                        begin
                            last_alloc_reg <= alloc_node;
                        end
                        state_reg <= ST_NODE;
                    end
                    else
                    begin
                        missing_reg <= 1'b1;
                        state_reg   <= ST_DONE;
                    end
                end

                ST_NODE:
                begin
                    state_reg <= ST_DONE;
                end

                ST_DONE:
                begin
                    // Hold until the output register is free.
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_CLEAR;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `TDWC_ASSERT_NOW(a_full_is_absent,
        out_valid_reg && pool_full_reg, !present_reg && (count_reg == '0),
        "pool_full result reports a present node")
    `TDWC_ASSERT_NOW(a_cursor_allocated,
        1'b1, cursor_reg <= last_alloc_reg,
        "cursor points past the last allocated node")
    `TDWC_ASSERT_NEXT(a_alloc_steps,
        state_reg != ST_CLEAR,
        (last_alloc_reg == $past(last_alloc_reg)) ||
        (last_alloc_reg == $past(last_alloc_reg) + 1'b1),
        "node allocation moved by more than one")

endmodule

/* test/trie_result_checker.sv */
// ----------------------------------------------------------------------------
// trie_result_checker
// Watches both channels of the trie counter, predicts every result from its
// own copy of the trie and compares each delivered result with the oldest
// prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module trie_result_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            command,
    input  logic [tdwc_pkg::LETTER_W-1:0]   letter,
    input  logic                            restart,
    input  logic [tdwc_pkg::TAG_W-1:0]      word_tag,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [tdwc_pkg::COUNT_W-1:0]    count,
    input  logic                            present,
    input  logic                            pool_full,
    output int                              mismatches,
    output int                              outstanding
);

    localparam int LINK_DEPTH = tdwc_pkg::NODE_COUNT * tdwc_pkg::ALPHABET_SIZE;

    typedef struct packed {
        logic [tdwc_pkg::COUNT_W-1:0] count;
        logic                         present;
        logic                         pool_full;
    } trie_result_t;

    // Shadow trie: child links, last tag and distinct count per node.
    logic [tdwc_pkg::NODE_W-1:0]  link_mem  [LINK_DEPTH];
    logic [tdwc_pkg::TAG_W-1:0]   tag_mem   [tdwc_pkg::NODE_COUNT];
    logic [tdwc_pkg::COUNT_W-1:0] count_mem [tdwc_pkg::NODE_COUNT];
    logic [tdwc_pkg::NODE_W-1:0]  alloc_top;
    logic [tdwc_pkg::NODE_W-1:0]  walk_node;
    logic                         walk_lost;

    trie_result_t due_results [$];

    // Advance the shadow trie by one letter and return the result it gives.
    function automatic trie_result_t walk_letter(input logic cmd,
                                                 input logic [tdwc_pkg::LETTER_W-1:0] ltr,
                                                 input logic rs,
                                                 input logic [tdwc_pkg::TAG_W-1:0] tag);
        trie_result_t                res;
        int                          slot;
        logic [tdwc_pkg::NODE_W-1:0] child;
        res = '0;
        if (rs) begin
            walk_node = '0;
            walk_lost = 1'b0;
        end
        if (walk_lost) begin
            return res;
        end
        if (int'(ltr) >= tdwc_pkg::ALPHABET_SIZE) begin
            walk_lost = 1'b1;
            return res;
        end
        slot  = int'(walk_node) * tdwc_pkg::ALPHABET_SIZE + int'(ltr);
        child = link_mem[slot];
        if (cmd == tdwc_pkg::CMD_QUERY) begin
            if (child == '0) begin
                walk_lost = 1'b1;
                return res;
            end
            walk_node   = child;
            res.count   = count_mem[child];
            res.present = 1'b1;
            return res;
        end
        if (child == '0) begin
            if (alloc_top == tdwc_pkg::NODE_W'(tdwc_pkg::NODE_COUNT - 1)) begin
                walk_lost     = 1'b1;
                res.pool_full = 1'b1;
                return res;
            end
            alloc_top      = alloc_top + 1'b1;
            child          = alloc_top;
            link_mem[slot] = child;
        end
        walk_node = child;
        if (tag_mem[child] != tag && count_mem[child] != tdwc_pkg::COUNT_MAX) begin
            count_mem[child] = count_mem[child] + 1'b1;
        end
        tag_mem[child] = tag;
        res.count      = count_mem[child];
        res.present    = 1'b1;
        return res;
    endfunction

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string field, input int got, input int want);
        mismatches++;
        $display("%0t ERROR %s: got %0d, predicted %0d", $time, field, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        trie_result_t want;
        if (!rst_n) begin
            for (int i = 0; i < LINK_DEPTH; i++) begin
                link_mem[i] = '0;
            end
            for (int i = 0; i < tdwc_pkg::NODE_COUNT; i++) begin
                tag_mem[i]   = '0;
                count_mem[i] = '0;
            end
            alloc_top = '0;
            walk_node = '0;
            walk_lost = 1'b0;
            due_results.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else begin
            // Check the delivered result before taking a new word.
            if (out_valid && out_ready) begin
                if (due_results.size() == 0) begin
                    report_mismatch("result with no word pending", int'(count), 0);
                end
                else begin
                    want = due_results.pop_front();
                    if (count !== want.count) begin
                        report_mismatch("count", int'(count), int'(want.count));
                    end
                    if (present !== want.present) begin
                        report_mismatch("present", int'(present), int'(want.present));
                    end
                    if (pool_full !== want.pool_full) begin
                        report_mismatch("pool_full", int'(pool_full), int'(want.pool_full));
                    end
                end
            end
            if (in_valid && in_ready) begin
                due_results.push_back(walk_letter(command, letter, restart, word_tag));
            end
            outstanding = due_results.size();
        end
    end

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives the trie distinct word counter with directed and random letters,
// including letters beyond the alphabet and tag zero, with random idling on
// both channels; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    logic                            command;
    logic [tdwc_pkg::LETTER_W-1:0]   letter;
    logic                            restart;
    logic [tdwc_pkg::TAG_W-1:0]      word_tag;
    logic                            out_valid;
    logic                            out_ready;
    logic [tdwc_pkg::COUNT_W-1:0]    count;
    logic                            present;
    logic                            pool_full;

    int mismatches;
    int outstanding;

    // Shared controls: idle_on enables random gaps on both sides, hold_go asks
    // the receiver for its one long hold-off.
    bit idle_on;
    bit hold_go;
    int words_sent;

    // Letters of the word currently being inserted or queried.
    logic [tdwc_pkg::LETTER_W-1:0] word_buf [8];
    int                            word_len;

    trie_distinct_word_counter_core uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .letter    (letter),
        .restart   (restart),
        .word_tag  (word_tag),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .count     (count),
        .present   (present),
        .pool_full (pool_full)
    );

    trie_result_checker result_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .letter      (letter),
        .restart     (restart),
        .word_tag    (word_tag),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .count       (count),
        .present     (present),
        .pool_full   (pool_full),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop: far beyond the slowest correct run, clearing sweep included.
    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Receiver: drop ready at random, and once hold it low for a long stretch
    // so the block backs up and stalls its input.
    initial
    begin : receiver
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_go && !hold_done) begin
                hold_done = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= !(idle_on && $urandom_range(99) < 33);
            end
        end
    end

    // Offer one word; idle for a random number of cycles first, then hold
    // valid and payload until the block takes it.
    task automatic send_word(input logic cmd,
                             input logic [tdwc_pkg::LETTER_W-1:0] ltr,
                             input logic rs,
                             input logic [tdwc_pkg::TAG_W-1:0] tag);
        while (idle_on && $urandom_range(99) < 33) begin
            @(negedge clk);
            in_valid <= 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        command  <= cmd;
        letter   <= ltr;
        restart  <= rs;
        word_tag <= tag;
        do @(posedge clk); while (!in_ready);
        words_sent++;
    endtask

    // Fill word_buf with a random word of 1 to 8 letters; most words use a
    // narrow alphabet so prefixes are shared.
    task automatic pick_word();
        int span;
        span     = ($urandom_range(3) == 0) ? 25 : 4;
        word_len = $urandom_range(1, 8);
        for (int i = 0; i < word_len; i++) begin
            word_buf[i] = tdwc_pkg::LETTER_W'($urandom_range(span));
        end
    endtask

    // Insert every suffix of word_buf under one tag, as the host would.
    task automatic insert_word(input logic [tdwc_pkg::TAG_W-1:0] tag);
        for (int s = 0; s < word_len; s++) begin
            for (int j = s; j < word_len; j++) begin
                send_word(tdwc_pkg::CMD_INSERT, word_buf[j], j == s, tag);
            end
        end
    endtask

    // Walk word_buf from the root with queries.
    task automatic query_word();
        for (int j = 0; j < word_len; j++) begin
            send_word(tdwc_pkg::CMD_QUERY, word_buf[j], j == 0, 16'($urandom));
        end
    endtask

    // Mixed traffic: a random mix of inserted words, queried words and noise.
    task automatic random_traffic(input int total);
        int                         pick;
        int                         stop_at;
        logic [tdwc_pkg::TAG_W-1:0] tag;
        tag     = 16'h0001;
        stop_at = words_sent + total;
        while (words_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                pick_word();
                // Reuse the previous tag now and then so shared prefixes
                // see the same word twice.
                if ($urandom_range(4) != 0) begin
                    tag = 16'($urandom_range(16'hFFFF, 1));
                end
                insert_word(tag);
            end
            else if (pick < 85) begin
                if ($urandom_range(1) == 0) begin
                    pick_word();
                end
                query_word();
            end
            else begin
                send_word(1'($urandom_range(1)), tdwc_pkg::LETTER_W'($urandom_range(31)),
                          1'($urandom_range(1)),
                          ($urandom_range(3) == 0) ? 16'h0000 : 16'($urandom));
            end
        end
    endtask

    initial
    begin : stimulus
        in_valid   = 1'b0;
        command    = tdwc_pkg::CMD_INSERT;
        letter     = '0;
        restart    = 1'b0;
        word_tag   = '0;
        idle_on    = 1'b1;
        hold_go    = 1'b0;
        words_sent = 0;
        rst_n      = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: missing paths on an empty trie.
        send_word(tdwc_pkg::CMD_QUERY,  5'd0,  1'b1, 16'h0001);
        send_word(tdwc_pkg::CMD_QUERY,  5'd1,  1'b0, 16'h0001);
        send_word(tdwc_pkg::CMD_INSERT, 5'd2,  1'b0, 16'h0001);
        // Build "az" and read it back.
        send_word(tdwc_pkg::CMD_INSERT, 5'd0,  1'b1, 16'hFFFF);
        send_word(tdwc_pkg::CMD_INSERT, 5'd25, 1'b0, 16'hFFFF);
        send_word(tdwc_pkg::CMD_QUERY,  5'd0,  1'b1, 16'h0000);
        send_word(tdwc_pkg::CMD_QUERY,  5'd25, 1'b0, 16'h0000);
        // Same tag must not count again; a new tag must.
        send_word(tdwc_pkg::CMD_INSERT, 5'd0,  1'b1, 16'hFFFF);
        send_word(tdwc_pkg::CMD_INSERT, 5'd0,  1'b1, 16'h0001);
        // Letters beyond the alphabet, for insert and query.
        send_word(tdwc_pkg::CMD_INSERT, 5'd26, 1'b1, 16'h1234);
        send_word(tdwc_pkg::CMD_INSERT, 5'd0,  1'b0, 16'h1234);
        send_word(tdwc_pkg::CMD_QUERY,  5'd31, 1'b1, 16'h1234);
        send_word(tdwc_pkg::CMD_INSERT, 5'd30, 1'b1, 16'h5678);
        // Tag zero on a fresh node leaves the count at zero.
        send_word(tdwc_pkg::CMD_INSERT, 5'd1,  1'b1, 16'h0000);
        send_word(tdwc_pkg::CMD_QUERY,  5'd1,  1'b1, 16'h0000);
        send_word(tdwc_pkg::CMD_INSERT, 5'd1,  1'b1, 16'h8000);
        send_word(tdwc_pkg::CMD_QUERY,  5'd1,  1'b1, 16'h0000);

        // Back-to-back stretch with no idling on either side.
        idle_on = 1'b0;
        random_traffic(300);
        idle_on = 1'b1;

        // Random words; ask for the long receiver hold-off early on.
        hold_go = 1'b1;
        random_traffic(1630);

        @(negedge clk);
        in_valid <= 1'b0;

        // Drain, then give the block time to show any stray result.
        while (outstanding != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatches == 0) begin
            $display("No mismatches found");
        end
        else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
